// File: rtl/core/bernoulli_categorical_sampler_defines.svh
// ----------------------------------------------------------------------------
// Bernoulli / categorical sampler assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BERNOULLI_CATEGORICAL_SAMPLER_DEFINES_SVH
`define BERNOULLI_CATEGORICAL_SAMPLER_DEFINES_SVH

// Same-cycle implication
`define BCS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bcs_pkg.sv
// ----------------------------------------------------------------------------
// Bernoulli / categorical sampler package
// Payload types, opcodes and generator constants for the sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

    // Width of the alternative counter (4 to 16)
    localparam int unsigned IndexBits = 16;

    // Opcodes
    localparam logic [1:0] OpFact  = 2'd0;
    localparam logic [1:0] OpFirst = 2'd1;
    localparam logic [1:0] OpNext  = 2'd2;

    // Result kinds
    localparam logic KindFact   = 1'b0;
    localparam logic KindChoice = 1'b1;

    // 48-bit LCG: x' = a*x + c mod 2^48
    localparam logic [47:0] LcgMul  = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LcgAdd  = 48'h0000_0000_000B;
    // Two steps at once: x'' = a^2*x + (a*c + c) mod 2^48
    localparam logic [47:0] LcgMul2 = LcgMul * LcgMul;
    localparam logic [47:0] LcgAdd2 = LcgMul * LcgAdd + LcgAdd;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [48:0] probability;
        logic        last;
    } bcs_in_t;

    typedef struct packed {
        logic        result_kind;
        logic        fact_true;
        logic [15:0] choice_index;
        logic        choice_none;
    } bcs_out_t;

endpackage

// File: rtl/core/bernoulli_categorical_sampler.sv
// ----------------------------------------------------------------------------
// Bernoulli / categorical sampler
// Random fact and categorical choice draws from a 48-bit LCG.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a seed write or a stalled result holds
// s_ready low; each result passes the input register, then the result
// register. Fact items and first alternatives each consume one generator
// value; the next value always sits ready in a register. The generator runs
// as a two-slot ring that advances by two LCG steps per pass, with the
// 48-bit multiply split into registered 24-bit partial products, so it
// yields one value per cycle. Writing the seed reloads the ring and holds
// s_ready low in the write cycle and while the first value is formed.
// Probabilities are unsigned 1.48 fractions.
// ----------------------------------------------------------------------------
module bernoulli_categorical_sampler
    import bcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Seed register
    input  logic        cfg_wr_en,
    input  logic [47:0] cfg_wr_data,
    // Item input
    input  logic        s_valid,
    output logic        s_ready,
    input  bcs_in_t     s_data,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output bcs_out_t    m_data
);

`include "bernoulli_categorical_sampler_defines.svh"

    // Partial products of a 48 x 48 multiply, mod 2^48
    typedef struct packed {
        logic [47:0] lo;
        logic [23:0] mid_a;
        logic [23:0] mid_b;
    } bcs_pp_t;

    // Generator ring
    bcs_pp_t     gen_pp_reg,   gen_pp_next;
    logic [47:0] gen_head_reg, gen_head_next;
    logic        prime_reg,    prime_next;
    logic [47:0] mul_x, mul_m, gen_sum, add_const;
    logic        gen_advance;

    // Input stage
    logic        s1_valid_reg, s1_valid_next;
    bcs_in_t     s1_item_reg;
    logic [47:0] s1_x_reg;

    // Choice state
    logic [47:0]          drawn_reg;
    logic [49:0]          cum_reg,   cum_next;
    logic [IndexBits-1:0] cnt_reg,   cnt_next;
    logic                 found_reg, found_next;
    logic [IndexBits-1:0] idx_reg,   idx_next;

    // Result stage
    logic        m_valid_reg, m_valid_next;
    bcs_out_t    m_data_reg,  m_data_next;

    logic        s_xfer, out_free, s1_go, s1_has_res;
    logic        is_fact, is_first, is_next;
    logic [49:0] x50, prob50;
    logic [50:0] sum51;
    logic        found_base, hit;
    logic [IndexBits-1:0] idx_base;

    // ------------------------------------------------------------------
    // Generator: head holds the next draw, ring advances on each draw
    // ------------------------------------------------------------------
    assign s_xfer      = s_valid && s_ready;
    assign gen_advance = s_xfer && (s_data.opcode == OpFact || s_data.opcode == OpFirst);

    assign mul_x     = cfg_wr_en ? cfg_wr_data : gen_head_reg;
    assign mul_m     = cfg_wr_en ? LcgMul : LcgMul2;
    assign add_const = prime_reg ? LcgAdd : LcgAdd2;
    assign gen_sum   = gen_pp_reg.lo
                     + {24'(gen_pp_reg.mid_a + gen_pp_reg.mid_b), 24'd0}
                     + add_const;

    always_comb begin
        gen_pp_next.lo    = 48'(mul_x[23:0]) * 48'(mul_m[23:0]);
        gen_pp_next.mid_a = 24'(mul_x[47:24] * mul_m[23:0]);
        gen_pp_next.mid_b = 24'(mul_x[23:0] * mul_m[47:24]);
    end

    always_comb begin
        gen_head_next = gen_head_reg;
        prime_next    = 1'b0;
        priority if (cfg_wr_en) begin
            // Keep the seed, start a single step from it
            gen_head_next = cfg_wr_data;
            prime_next    = 1'b1;
        end else if (prime_reg || gen_advance) begin
            gen_head_next = gen_sum;
        end else begin
            // Hold the waiting draw
            gen_head_next = gen_head_reg;
        end
    end

    // Reset state matches seed zero: head = c, pending product = 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_pp_reg   <= '0;
            gen_head_reg <= LcgAdd;
            prime_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en || prime_reg || gen_advance) begin
                gen_pp_reg <= gen_pp_next;
            end
            gen_head_reg <= gen_head_next;
            prime_reg    <= prime_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign is_fact  = (s1_item_reg.opcode == OpFact);
    assign is_first = (s1_item_reg.opcode == OpFirst);
    assign is_next  = (s1_item_reg.opcode == OpNext);

    assign s1_has_res = is_fact || ((is_first || is_next) && s1_item_reg.last);
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_go      = s1_valid_reg && (!s1_has_res || out_free);
    assign s_ready    = !prime_reg && !cfg_wr_en && (!s1_valid_reg || s1_go);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        priority if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Capture the item with its draw
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_item_reg <= s_data;
            s1_x_reg    <= gen_head_reg;
        end
    end

    // ------------------------------------------------------------------
    // Choice accumulation and result
    // ------------------------------------------------------------------
    assign x50    = {2'b00, (is_first ? s1_x_reg : drawn_reg)};
    assign prob50 = {1'b0, s1_item_reg.probability};
    assign sum51  = {1'b0, cum_reg} + {1'b0, prob50};

    always_comb begin
        if (is_first) begin
            cum_next   = prob50;
            cnt_next   = '0;
            found_base = 1'b0;
            idx_base   = '0;
        end else begin
            // Saturate the running sum
            cum_next   = sum51[50] ? '1 : sum51[49:0];
            cnt_next   = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
            found_base = found_reg;
            idx_base   = idx_reg;
        end
        hit        = !found_base && (x50 < cum_next);
        found_next = found_base || hit;
        idx_next   = hit ? cnt_next : idx_base;
    end

    always_comb begin
        m_data_next = '0;
        if (is_fact) begin
            m_data_next.result_kind = KindFact;
            m_data_next.fact_true   = ({1'b0, s1_x_reg} <= s1_item_reg.probability);
        end else begin
            m_data_next.result_kind  = KindChoice;
            m_data_next.choice_index = found_next ? 16'(idx_next) : 16'd0;
            m_data_next.choice_none  = !found_next;
        end
    end

    // Update choice state once the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drawn_reg <= '0;
            cum_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (s1_go && (is_first || is_next)) begin
            if (is_first) begin
                drawn_reg <= s1_x_reg;
            end
            cum_reg   <= cum_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the result until transferred
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (s1_go && s1_has_res) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_has_res) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BCS_ASSERT_NEXT(a_seed_blocks_input, aclk, aresetn, cfg_wr_en, !s_ready,
        "input taken while the generator reprimes")

    `BCS_ASSERT_NEXT(a_draw_moves_head, aclk, aresetn, gen_advance && !cfg_wr_en,
        gen_head_reg != $past(gen_head_reg), "generator did not advance on a draw")

    `BCS_ASSERT_NEXT(a_fact_result, aclk, aresetn, s1_go && is_fact,
        m_valid && m_data.result_kind == KindFact, "fact item gave no fact result")

    `BCS_ASSERT_SAME(a_none_zero_index, aclk, aresetn, m_valid && m_data.choice_none,
        m_data.choice_index == 16'd0, "choice index set with no alternative found")

    `BCS_ASSERT_NEXT(a_found_sticky, aclk, aresetn, s1_go && is_next && found_reg,
        found_reg && idx_reg == $past(idx_reg), "found alternative changed within a choice")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Bernoulli / categorical sampler testbench
// Drives fact draws and categorical choice sequences through the sampler
// under several seeds and idling patterns. It predicts every result from
// its own copy of the 48-bit generator and choice state and checks each
// field of each result transfer in order.
// ----------------------------------------------------------------------------
module tb
    import bcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Generator constants and limits, kept apart from the design
    localparam logic [47:0] LcgA        = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LcgC        = 48'h0000_0000_000B;
    localparam logic [50:0] SumMax      = {1'b0, {50{1'b1}}};
    localparam logic [15:0] IdxMax      = 16'((32'd1 << IndexBits) - 32'd1);
    localparam logic [1:0]  OpUnused    = 2'd3;
    localparam logic [48:0] ProbOne     = 49'h1_0000_0000_0000;
    localparam logic [48:0] ProbHalf    = 49'h0_8000_0000_0000;
    localparam logic [48:0] ProbAll     = {49{1'b1}};
    localparam int          DrainCycles = 6;
    localparam int          CycleLimit  = 1_000_000;

    // Expected results and the sampler state that produces them
    class draw_scoreboard;
        logic [47:0] lcg_state;
        logic [47:0] choice_x;
        logic [49:0] run_sum;
        logic [15:0] alt_count;
        logic        hit;
        logic [15:0] hit_index;
        bcs_out_t    expected_q[$];
        int          errors;

        function new();
            lcg_state = '0;
            choice_x  = '0;
            run_sum   = '0;
            alt_count = '0;
            hit       = 1'b0;
            hit_index = '0;
            errors    = 0;
        endfunction

        function void load_seed(logic [47:0] seed_value);
            lcg_state = seed_value;
        endfunction

        function logic [47:0] step_lcg();
            lcg_state = lcg_state * LcgA + LcgC;
            return lcg_state;
        endfunction

        // Update the state for one accepted transfer and queue its result
        function void note_item(bcs_in_t item);
            bcs_out_t    res;
            logic [47:0] x;
            logic [50:0] wide;
            res = '0;
            if (item.opcode == OpFact) begin
                x = step_lcg();
                res.result_kind = KindFact;
                res.fact_true   = ({1'b0, x} <= item.probability);
                expected_q.push_back(res);
            end else if (item.opcode == OpFirst || item.opcode == OpNext) begin
                if (item.opcode == OpFirst) begin
                    choice_x  = step_lcg();
                    run_sum   = {1'b0, item.probability};
                    alt_count = '0;
                    hit       = 1'b0;
                    hit_index = '0;
                end else begin
                    // Saturate the running sum and the alternative counter
                    wide    = {1'b0, run_sum} + {2'b0, item.probability};
                    run_sum = (wide > SumMax) ? SumMax[49:0] : wide[49:0];
                    if (alt_count < IdxMax) begin
                        alt_count = alt_count + 16'd1;
                    end
                end
                if (!hit && {2'b0, choice_x} < run_sum) begin
                    hit       = 1'b1;
                    hit_index = alt_count;
                end
                if (item.last) begin
                    res.result_kind  = KindChoice;
                    res.choice_index = hit ? hit_index : '0;
                    res.choice_none  = !hit;
                    expected_q.push_back(res);
                end
            end
        endfunction

        function void report_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            errors++;
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(bcs_out_t got);
            bcs_out_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.result_kind !== exp_r.result_kind)
                report_field("result_kind", 16'(exp_r.result_kind), 16'(got.result_kind));
            if (got.fact_true !== exp_r.fact_true)
                report_field("fact_true", 16'(exp_r.fact_true), 16'(got.fact_true));
            if (got.choice_index !== exp_r.choice_index)
                report_field("choice_index", exp_r.choice_index, got.choice_index);
            if (got.choice_none !== exp_r.choice_none)
                report_field("choice_none", 16'(exp_r.choice_none), 16'(got.choice_none));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [47:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    bcs_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    bcs_out_t    m_data;

    draw_scoreboard sb = new();
    int             idle_pct;
    int             stall_pct;
    int             cycle_count;

    bernoulli_categorical_sampler u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [48:0] rand_prob();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ProbOne;
            2:       return w[48:0];
            default: return {1'b0, w[47:0]};
        endcase
    endfunction

    // Offer one item after an optional gap and hold it until the transfer
    task automatic send_item(logic [1:0] op, logic [48:0] prob, logic last);
        bcs_in_t item;
        item.opcode      = op;
        item.probability = prob;
        item.last        = last;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(item);
    endtask

    // Drop valid and wait for every expected result plus the pipeline tail
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_seed(logic [47:0] seed_value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed_value;
        @(posedge aclk);
        sb.load_seed(seed_value);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed choices and facts, with orphan and unused items as noise
    task automatic run_random(int n_items);
        int          sent;
        int          n_alt;
        int          r;
        logic [63:0] w;
        logic [48:0] p;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_item(OpFact, rand_prob(), 1'($urandom_range(0, 1)));
                sent++;
            end else if (r < 85) begin
                n_alt = $urandom_range(1, 8);
                for (int k = 0; k < n_alt; k++) begin
                    w = {$urandom, $urandom};
                    if ($urandom_range(0, 7) == 0)
                        p = rand_prob();
                    else
                        p = 49'((50'(w[47:0]) << 1) / n_alt);
                    send_item((k == 0) ? OpFirst : OpNext, p,
                              (k == n_alt - 1) || ($urandom_range(0, 15) == 0));
                    sent++;
                    // Slip a fact or an unused opcode into the choice now and then
                    if (k < n_alt - 1 && $urandom_range(0, 9) == 0) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_item(OpFact, rand_prob(), 1'b0);
                            sent++;
                        end else begin
                            send_item(OpUnused, rand_prob(), 1'($urandom_range(0, 1)));
                        end
                    end
                end
            end else if (r < 93) begin
                send_item(OpNext, rand_prob(), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_item(OpUnused, rand_prob(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        m_ready     <= 1'b1;
        idle_pct    = 0;
        stall_pct   = 0;
        cycle_count = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items on the reset seed
        send_item(OpFact, '0, 1'b0);
        send_item(OpFact, ProbOne, 1'b0);
        send_item(OpFact, ProbAll, 1'b1);
        send_item(OpUnused, ProbAll, 1'b1);
        // Next alternative without a first, then again after its last
        send_item(OpNext, '0, 1'b1);
        send_item(OpNext, 49'd1, 1'b1);
        send_item(OpFirst, '0, 1'b0);
        send_item(OpNext, ProbHalf, 1'b0);
        send_item(OpUnused, '0, 1'b0);
        send_item(OpNext, ProbHalf, 1'b1);
        send_item(OpFirst, ProbOne, 1'b1);
        send_item(OpFirst, '0, 1'b1);
        // Fact draw in the middle of a choice
        send_item(OpFirst, '0, 1'b0);
        send_item(OpFact, 49'h0_AAAA_AAAA_AAAA, 1'b0);
        send_item(OpNext, ProbOne, 1'b1);
        // Saturate the running sum, then keep accumulating past the last
        send_item(OpFirst, ProbAll, 1'b0);
        send_item(OpNext, ProbAll, 1'b0);
        send_item(OpNext, ProbAll, 1'b1);
        send_item(OpNext, '0, 1'b1);
        send_item(OpFact, 49'h1_5555_5555_5555, 1'b0);
        send_item(OpFact, 49'h0_5555_5555_5555, 1'b1);
        wait_for_quiet();

        // No idling, top seed
        write_seed(48'hFFFF_FFFF_FFFF);
        run_random(110);
        wait_for_quiet();

        // Sender idling, with one pause until all results are back
        write_seed(48'({$urandom, $urandom}));
        idle_pct = 61;
        run_random(55);
        wait_for_quiet();
        run_random(55);
        wait_for_quiet();

        // Receiver stalling, zero seed
        write_seed('0);
        idle_pct  = 0;
        stall_pct = 61;
        run_random(110);
        wait_for_quiet();

        // Both sides idling
        write_seed(48'({$urandom, $urandom}));
        idle_pct  = 17;
        stall_pct = 17;
        run_random(110);
        wait_for_quiet();

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
